// ===== hw/rtl/yca_pkg.sv =====
// Shared types and register codes for the YUV colour adjustment block.
`default_nettype none

package yca_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 14;

  localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CONTRAST   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SATURATION = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HUE_SINE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HUE_COSINE = 3'd4;

  localparam logic CMD_LUMA   = 1'b0;
  localparam logic CMD_CHROMA = 1'b1;

  // Q12 unity for the hue cosine
  localparam logic signed [13:0] HUE_UNITY = 14'sd4096;
  // Q9 unity gain
  localparam logic signed [11:0] GAIN_UNITY = 12'sd512;

  typedef struct packed {
    logic       command;
    logic [7:0] luma_in;
    logic [7:0] cb_in;
    logic [7:0] cr_in;
  } yca_in_t;

  typedef struct packed {
    logic [7:0] luma_out;
    logic [7:0] cb_out;
    logic [7:0] cr_out;
  } yca_out_t;

  // Derived coefficients as the datapath uses them
  typedef struct packed {
    logic signed [11:0] c_gain;
    logic signed [10:0] b_off;
    logic signed [11:0] s_gain;
    logic signed [13:0] hue_sine;
    logic signed [13:0] hue_cosine;
    logic               luma_bypass;
    logic               chroma_bypass;
  } yca_cfg_t;

endpackage

`default_nettype wire

// ===== hw/rtl/yca_cfg_regs.sv =====
// Configuration registers and derivation of the luma and chroma gains, the luma offset and the bypass flags.
`default_nettype none

module yca_cfg_regs (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [yca_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [yca_pkg::CFG_DATA_W-1:0] cfg_data,
  output yca_pkg::yca_cfg_t                   cfg
);
  import yca_pkg::*;

  logic signed [7:0]  brightness;
  logic signed [7:0]  contrast;
  logic signed [7:0]  saturation;
  logic signed [13:0] hue_sine;
  logic signed [13:0] hue_cosine;
  logic signed [11:0] c_gain;
  logic signed [10:0] b_off;
  logic signed [11:0] s_gain;

  // trunc(pct*512/100) + 512; pct*512/100 = pct*128/25, 1/25 by reciprocal 5243/2^17
  function automatic logic signed [11:0] gain_q9(input logic signed [7:0] pct);
    logic [7:0]         mag;
    logic [14:0]        n;
    logic [27:0]        prod;
    logic [10:0]        q;
    logic signed [11:0] qs;
    mag  = pct[7] ? 8'(-pct) : 8'(pct);
    n    = {mag, 7'b0};
    prod = 28'(n) * 28'd5243;
    q    = prod[27:17];
    qs   = signed'({1'b0, q});
    return (pct[7] ? -qs : qs) + GAIN_UNITY;
  endfunction

  // trunc(pct*255/100) = sign * floor(floor(|pct|*51/4)/5), 1/5 by 52429/2^18
  function automatic logic signed [10:0] offset_luma(input logic signed [7:0] pct);
    logic [7:0]         mag;
    logic [12:0]        n;
    logic [10:0]        m;
    logic [27:0]        prod;
    logic [9:0]         q;
    logic signed [10:0] qs;
    mag  = pct[7] ? 8'(-pct) : 8'(pct);
    n    = 13'(mag) * 13'd51;
    m    = n[12:2];
    prod = 28'(m) * 28'd52429;
    q    = prod[27:18];
    qs   = signed'({1'b0, q});
    return pct[7] ? -qs : qs;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      brightness <= '0;
      contrast   <= '0;
      saturation <= '0;
      hue_sine   <= '0;
      hue_cosine <= HUE_UNITY;
      c_gain     <= GAIN_UNITY;
      b_off      <= '0;
      s_gain     <= GAIN_UNITY;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BRIGHTNESS: begin
          brightness <= cfg_data[7:0];
          b_off      <= offset_luma(cfg_data[7:0]);
        end
        CFG_CONTRAST: begin
          contrast <= cfg_data[7:0];
          c_gain   <= gain_q9(cfg_data[7:0]);
        end
        CFG_SATURATION: begin
          saturation <= cfg_data[7:0];
          s_gain     <= gain_q9(cfg_data[7:0]);
        end
        CFG_HUE_SINE:   hue_sine   <= cfg_data;
        CFG_HUE_COSINE: hue_cosine <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.c_gain        = c_gain;
    cfg.b_off         = b_off;
    cfg.s_gain        = s_gain;
    cfg.hue_sine      = hue_sine;
    cfg.hue_cosine    = hue_cosine;
    cfg.luma_bypass   = (brightness == '0) && (contrast == '0);
    cfg.chroma_bypass = (saturation == '0) && (hue_sine == '0) &&
                        (hue_cosine == HUE_UNITY);
  end

endmodule

`default_nettype wire

// ===== hw/rtl/yuv_color_adjust_core.sv =====
// Top level: four-stage pipeline for luma contrast/brightness and chroma hue/saturation.
`default_nettype none

// Each transfer carries one luma sample (command 0) or one U/V pair (command 1)
// and yields one result from the output register; one item is taken every clock while
// the output side keeps taking results. Stage 1 forms the gain and rotation
// products, stage 2 sums and shifts them (and finishes luma), stage 3 applies
// the saturation gain, stage 4 re-centres, clamps and selects bypass into the
// output register. Each stage holds while the stage after it is full and
// stalled, so backpressure ripples back to in_ready. Unused result fields are
// zero. Registers may be written only while no item is in flight.
module yuv_color_adjust_core (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [yca_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [yca_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire yca_pkg::yca_in_t               in_data,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output yca_pkg::yca_out_t                   out_data
);
  import yca_pkg::*;

  yca_cfg_t cfg;

  yca_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // stage valids and per-stage ready
  logic v1, v2, v3;
  logic ready1, ready2, ready3, ready4;

  assign ready4   = !out_valid || out_ready;
  assign ready3   = !v3 || ready4;
  assign ready2   = !v2 || ready3;
  assign ready1   = !v1 || ready2;
  assign in_ready = ready1;

  // stage 1: products
  yca_in_t            d1;
  logic signed [20:0] lprod1;
  logic signed [22:0] uc1, us1, vc1, vs1;

  logic signed [8:0]  y_ctr, u_ctr, v_ctr;
  logic signed [20:0] lprod;
  logic signed [22:0] uc, us, vc, vs;

  always_comb begin
    y_ctr = signed'({1'b0, in_data.luma_in}) - 9'sd16;
    u_ctr = signed'({1'b0, in_data.cb_in}) - 9'sd128;
    v_ctr = signed'({1'b0, in_data.cr_in}) - 9'sd128;
    lprod = 21'(cfg.c_gain) * 21'(y_ctr);
    uc    = 23'(u_ctr) * 23'(cfg.hue_cosine);
    us    = 23'(u_ctr) * 23'(cfg.hue_sine);
    vc    = 23'(v_ctr) * 23'(cfg.hue_cosine);
    vs    = 23'(v_ctr) * 23'(cfg.hue_sine);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (ready1) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready1 && in_valid) begin
      d1     <= in_data;
      lprod1 <= lprod;
      uc1    <= uc;
      us1    <= us;
      vc1    <= vc;
      vs1    <= vs;
    end
  end

  // stage 2: rotation sums, luma finish
  yca_in_t            d2;
  logic signed [11:0] ur2, vr2;
  logic [7:0]         luma2;

  logic signed [23:0] ur_sum, vr_sum;
  logic signed [11:0] lsh;
  logic signed [12:0] lsum;
  logic [7:0]         luma_clip;

  always_comb begin
    ur_sum = 24'(uc1) + 24'(vs1);
    vr_sum = 24'(vc1) - 24'(us1);
    lsh    = lprod1[20:9];
    lsum   = 13'(lsh) + 13'(cfg.b_off) + 13'sd16;
    if (lsum < 13'sd0) begin
      luma_clip = 8'd0;
    end else if (lsum > 13'sd255) begin
      luma_clip = 8'd255;
    end else begin
      luma_clip = lsum[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (ready2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (ready2 && v1) begin
      d2    <= d1;
      ur2   <= ur_sum[23:12];
      vr2   <= vr_sum[23:12];
      luma2 <= luma_clip;
    end
  end

  // stage 3: saturation gain
  yca_in_t            d3;
  logic signed [23:0] usat3, vsat3;
  logic [7:0]         luma3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (ready3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (ready3 && v2) begin
      d3    <= d2;
      usat3 <= 24'(ur2) * 24'(cfg.s_gain);
      vsat3 <= 24'(vr2) * 24'(cfg.s_gain);
      luma3 <= luma2;
    end
  end

  // stage 4: re-centre, clamp, bypass, output register
  function automatic logic [7:0] chroma_clip(input logic signed [23:0] p);
    logic signed [14:0] sh;
    logic signed [15:0] sum;
    sh  = p[23:9];
    sum = 16'(sh) + 16'sd128;
    if (sum < 16'sd16) begin
      return 8'd16;
    end else if (sum > 16'sd235) begin
      return 8'd235;
    end
    return sum[7:0];
  endfunction

  yca_out_t result;

  always_comb begin
    result = '0;
    if (d3.command == CMD_CHROMA) begin
      if (cfg.chroma_bypass) begin
        result.cb_out = d3.cb_in;
        result.cr_out = d3.cr_in;
      end else begin
        result.cb_out = chroma_clip(usat3);
        result.cr_out = chroma_clip(vsat3);
      end
    end else begin
      result.luma_out = cfg.luma_bypass ? d3.luma_in : luma3;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready4) begin
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (ready4 && v3) begin
      out_data <= result;
    end
  end

  // a refused input means every stage is full and the output is stalled
  a_full_when_blocked: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (v1 && v2 && v3 && out_valid && !out_ready))
    else $error("input blocked while the pipeline has a free stage");

  a_reset_empties: assert property (@(posedge clk)
    rst |=> (!v1 && !v2 && !v3 && !out_valid))
    else $error("pipeline not empty after reset");

  a_one_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_data.luma_out == 8'd0) ||
                   (out_data.cb_out == 8'd0 && out_data.cr_out == 8'd0)))
    else $error("result carries both luma and chroma");

  a_stall_holds_stage3: assert property (@(posedge clk) disable iff (rst)
    (v3 && !ready4) |=> (v3 && $stable(usat3) && $stable(luma3)))
    else $error("stage 3 changed during a stall");

endmodule

`default_nettype wire
